@@ rtl/atatf_pkg.sv @@
// Shared constants for the ATA task-file address builder.
// No dependencies; imported by ata_taskfile_address_builder.
package atatf_pkg;

  localparam int unsigned LbaW      = 32;
  localparam int unsigned Lba28W    = 28;
  localparam int unsigned QuotW     = 23;   // floor((2^28 - 1) / 63) fits in 23 bits
  localparam int unsigned ProdW     = Lba28W + 29;
  localparam int unsigned RecipShift = 34;

  // floor(2^34 / 63); the estimate it gives is the true quotient or one less.
  localparam logic [28:0] RECIP_63  = 29'd272696336;
  localparam logic [6:0]  CHS_SECT  = 7'd63;

  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_LBA48 = 2'd2;

  localparam logic [7:0] DEV_BASE_CHS = 8'hA0;
  localparam logic [7:0] DEV_BASE_LBA = 8'hE0;

  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
  localparam logic [7:0] CMD_FLUSH     = 8'hE7;
  localparam logic [7:0] CMD_FLUSH_EXT = 8'hEA;

endpackage

@@ rtl/ata_taskfile_address_builder.sv @@
// ATA task-file address builder: three register stages, one transaction per clock.
// A transaction accepted on start passes through the stage 1, stage 2 and output registers
// before it appears on out_* with out_valid. Throughput: one transaction every cycle.
// The receiver cannot stall, so results are strobed for exactly one cycle; busy stays low.
// Reset (rst_n low, synchronous) clears the stage valid bits; payload registers are not reset.
// Depends on atatf_pkg for mode, device-base and command codes.
module ata_taskfile_address_builder
  import atatf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_direction,
  input  logic [31:0] in_lba,
  input  logic [7:0]  in_sector_count,
  input  logic        in_is_slave,
  input  logic        in_lba_capable,
  output logic        out_valid,
  output logic [1:0]  out_address_mode,
  output logic [7:0]  out_device_head,
  output logic [7:0]  out_count_byte,
  output logic [7:0]  out_addr_byte0,
  output logic [7:0]  out_addr_byte1,
  output logic [7:0]  out_addr_byte2,
  output logic [7:0]  out_addr_byte3,
  output logic [7:0]  out_addr_byte4,
  output logic [7:0]  out_addr_byte5,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_flush_code
);

  // Every stage moves forward each cycle and the output is a pure strobe, so
  // nothing can back up: the block is always ready for the next transaction.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request.
  // ---------------------------------------------------------------------------
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_dir_r;
  logic [LbaW-1:0]   s1_lba_r;
  logic [7:0]        s1_count_r;
  logic              s1_slave_r;
  logic              s1_cap_r;

  assign s1_valid_nxt = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_dir_r   <= in_direction;
    s1_lba_r   <= in_lba;
    s1_count_r <= in_sector_count;
    s1_slave_r <= in_is_slave;
    s1_cap_r   <= in_lba_capable;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: choose the addressing mode and estimate lba / 63 with a
  // reciprocal multiply. Only the CHS path uses the quotient, and that path
  // is taken only when the address is below 2^28, so 28 bits suffice.
  // ---------------------------------------------------------------------------
  logic              s2_valid_r;
  logic              s2_dir_r;
  logic [LbaW-1:0]   s2_lba_r;
  logic [7:0]        s2_count_r;
  logic              s2_slave_r;
  logic [1:0]        s2_mode_r, s2_mode_nxt;
  logic [QuotW-1:0]  s2_quot_r, s2_quot_nxt;
  logic [ProdW-1:0]  s2_prod;

  always_comb begin
    if (s1_lba_r[LbaW-1:Lba28W] != '0) begin
      s2_mode_nxt = MODE_LBA48;
    end else if (s1_cap_r) begin
      s2_mode_nxt = MODE_LBA28;
    end else begin
      s2_mode_nxt = MODE_CHS;
    end
    s2_prod     = {{(ProdW-Lba28W){1'b0}}, s1_lba_r[Lba28W-1:0]} *
                  {{(ProdW-29){1'b0}}, RECIP_63};
    s2_quot_nxt = s2_prod[RecipShift +: QuotW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_dir_r   <= s1_dir_r;
    s2_lba_r   <= s1_lba_r;
    s2_count_r <= s1_count_r;
    s2_slave_r <= s1_slave_r;
    s2_mode_r  <= s2_mode_nxt;
    s2_quot_r  <= s2_quot_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: correct the quotient by one if needed, split it into head and
  // cylinder, and assemble the task-file bytes into the output register.
  // The quotient is the track number; head is its low nibble and the
  // cylinder the next 16 bits, truncated as the drive register holds them.
  // ---------------------------------------------------------------------------
  logic [Lba28W-1:0] s3_times63;
  logic [Lba28W-1:0] s3_rem_full;
  logic [6:0]        s3_rem;
  logic [QuotW-1:0]  s3_quot;
  logic [6:0]        s3_sect;
  logic [3:0]        s3_head;
  logic [15:0]       s3_cyl;

  logic        out_valid_r;
  logic [1:0]  out_mode_r, out_mode_nxt;
  logic [7:0]  out_devhead_r, out_devhead_nxt;
  logic [7:0]  out_count_r;
  logic [7:0]  out_b0_r, out_b0_nxt;
  logic [7:0]  out_b1_r, out_b1_nxt;
  logic [7:0]  out_b2_r, out_b2_nxt;
  logic [7:0]  out_b3_r, out_b3_nxt;
  logic [7:0]  out_cmd_r, out_cmd_nxt;
  logic [7:0]  out_flush_r, out_flush_nxt;

  always_comb begin
    // The product is only needed modulo 2^28, since the remainder is small.
    s3_times63  = {s2_quot_r[Lba28W-7:0], 6'b0} -
                  {{(Lba28W-QuotW){1'b0}}, s2_quot_r};
    s3_rem_full = s2_lba_r[Lba28W-1:0] - s3_times63;
    s3_rem      = s3_rem_full[6:0];
    if (s3_rem >= CHS_SECT) begin
      s3_quot = s2_quot_r + {{(QuotW-1){1'b0}}, 1'b1};
      s3_sect = s3_rem - CHS_SECT + 7'd1;
    end else begin
      s3_quot = s2_quot_r;
      s3_sect = s3_rem + 7'd1;
    end
    s3_head = s3_quot[3:0];
    s3_cyl  = s3_quot[19:4];

    out_mode_nxt  = s2_mode_r;
    out_cmd_nxt   = s2_dir_r ? CMD_WRITE : CMD_READ;
    out_flush_nxt = CMD_FLUSH;
    case (s2_mode_r)
      MODE_LBA48: begin
        out_devhead_nxt = DEV_BASE_LBA | {3'b0, s2_slave_r, 4'b0};
        out_b0_nxt      = s2_lba_r[7:0];
        out_b1_nxt      = s2_lba_r[15:8];
        out_b2_nxt      = s2_lba_r[23:16];
        out_b3_nxt      = s2_lba_r[31:24];
        out_cmd_nxt     = s2_dir_r ? CMD_WRITE_EXT : CMD_READ_EXT;
        out_flush_nxt   = CMD_FLUSH_EXT;
      end
      MODE_LBA28: begin
        out_devhead_nxt = DEV_BASE_LBA | {3'b0, s2_slave_r, s2_lba_r[27:24]};
        out_b0_nxt      = s2_lba_r[7:0];
        out_b1_nxt      = s2_lba_r[15:8];
        out_b2_nxt      = s2_lba_r[23:16];
        out_b3_nxt      = 8'h00;
      end
      default: begin
        out_devhead_nxt = DEV_BASE_CHS | {3'b0, s2_slave_r, s3_head};
        out_b0_nxt      = {1'b0, s3_sect};
        out_b1_nxt      = s3_cyl[7:0];
        out_b2_nxt      = s3_cyl[15:8];
        out_b3_nxt      = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_mode_r    <= out_mode_nxt;
    out_devhead_r <= out_devhead_nxt;
    out_count_r   <= s2_count_r;
    out_b0_r      <= out_b0_nxt;
    out_b1_r      <= out_b1_nxt;
    out_b2_r      <= out_b2_nxt;
    out_b3_r      <= out_b3_nxt;
    out_cmd_r     <= out_cmd_nxt;
    out_flush_r   <= out_flush_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_address_mode = out_mode_r;
  assign out_device_head  = out_devhead_r;
  assign out_count_byte   = out_count_r;
  assign out_addr_byte0   = out_b0_r;
  assign out_addr_byte1   = out_b1_r;
  assign out_addr_byte2   = out_b2_r;
  assign out_addr_byte3   = out_b3_r;
  // The upper LBA48 bytes are always zero for a 32-bit block address.
  assign out_addr_byte4   = 8'h00;
  assign out_addr_byte5   = 8'h00;
  assign out_command_code = out_cmd_r;
  assign out_flush_code   = out_flush_r;

endmodule

@@ tb/tb_ata_taskfile_address_builder.sv @@
// Self-checking testbench for the ATA task-file address builder.
// Drives sector-access requests, predicts the task-file bytes, and checks each strobed result.
// Depends on atatf_pkg and the ata_taskfile_address_builder RTL.
`timescale 1ns / 1ps

module tb_ata_taskfile_address_builder
  import atatf_pkg::*;
;

  // Clock and run limits. The slowest correct run is roughly 925 transactions
  // plus the random idle bursts between them, plus the pipeline depth, so the
  // watchdog sits well above that.
  localparam int          HalfPeriod = 6;
  localparam int          ResetCycles = 7;
  localparam int          RandomCount = 900;
  localparam int          CalmTail = 150;
  localparam int          DrainCycles = 8;
  localparam int          CycleLimit = 80000;
  localparam int          MaxPrinted = 60;

  // Address geometry used by the predictor.
  localparam logic [31:0] Lba48Floor = 32'h1000_0000;
  localparam logic [31:0] ChsHeads = 32'd16;

  typedef struct packed {
    logic        direction;
    logic [31:0] lba;
    logic [7:0]  sector_count;
    logic        is_slave;
    logic        lba_capable;
  } sector_request_t;

  typedef struct packed {
    logic [1:0] address_mode;
    logic [7:0] device_head;
    logic [7:0] count_byte;
    logic [7:0] addr_byte0;
    logic [7:0] addr_byte1;
    logic [7:0] addr_byte2;
    logic [7:0] addr_byte3;
    logic [7:0] addr_byte4;
    logic [7:0] addr_byte5;
    logic [7:0] command_code;
    logic [7:0] flush_code;
  } taskfile_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_direction = 1'b0;
  logic [31:0] in_lba = '0;
  logic [7:0]  in_sector_count = '0;
  logic        in_is_slave = 1'b0;
  logic        in_lba_capable = 1'b0;
  logic        out_valid;
  logic [1:0]  out_address_mode;
  logic [7:0]  out_device_head;
  logic [7:0]  out_count_byte;
  logic [7:0]  out_addr_byte0;
  logic [7:0]  out_addr_byte1;
  logic [7:0]  out_addr_byte2;
  logic [7:0]  out_addr_byte3;
  logic [7:0]  out_addr_byte4;
  logic [7:0]  out_addr_byte5;
  logic [7:0]  out_command_code;
  logic [7:0]  out_flush_code;

  // Requests waiting to be driven, and task-file images waiting to come out.
  sector_request_t request_q[$];
  taskfile_t       taskfile_expect_q[$];

  int          total_requests = 0;
  int          accepted_count = 0;
  int          checked_count = 0;
  int          mismatch_count = 0;
  int          mode_seen[3] = '{0, 0, 0};
  int          cycle_count = 0;
  int          idle_left = 0;
  bit          feeding = 1'b0;
  bit          took_request = 1'b0;
  sector_request_t next_request;

  ata_taskfile_address_builder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_direction     (in_direction),
    .in_lba           (in_lba),
    .in_sector_count  (in_sector_count),
    .in_is_slave      (in_is_slave),
    .in_lba_capable   (in_lba_capable),
    .out_valid        (out_valid),
    .out_address_mode (out_address_mode),
    .out_device_head  (out_device_head),
    .out_count_byte   (out_count_byte),
    .out_addr_byte0   (out_addr_byte0),
    .out_addr_byte1   (out_addr_byte1),
    .out_addr_byte2   (out_addr_byte2),
    .out_addr_byte3   (out_addr_byte3),
    .out_addr_byte4   (out_addr_byte4),
    .out_addr_byte5   (out_addr_byte5),
    .out_command_code (out_command_code),
    .out_flush_code   (out_flush_code)
  );

  always #HalfPeriod clk = ~clk;

  // Works out the task-file image for one request. Addresses at or above 2^28
  // need the 48-bit command set no matter what the drive claims; below that, an
  // LBA-capable drive takes 28-bit LBA with bits 27:24 in the head nibble, and
  // anything else falls back to CHS with 63 sectors per track and 16 heads.
  function automatic taskfile_t build_taskfile(input sector_request_t req);
    taskfile_t   tf;
    logic [31:0] sector_num;
    logic [31:0] track_base;
    logic [31:0] cylinder;
    logic [3:0]  head;
    logic [7:0]  base;
    tf = '0;
    tf.count_byte = req.sector_count;
    if (req.lba >= Lba48Floor) begin
      tf.address_mode = MODE_LBA48;
      {tf.addr_byte3, tf.addr_byte2, tf.addr_byte1, tf.addr_byte0} = req.lba;
      head = 4'd0;
      base = DEV_BASE_LBA;
    end else if (req.lba_capable) begin
      tf.address_mode = MODE_LBA28;
      {tf.addr_byte2, tf.addr_byte1, tf.addr_byte0} = req.lba[23:0];
      head = req.lba[27:24];
      base = DEV_BASE_LBA;
    end else begin
      tf.address_mode = MODE_CHS;
      sector_num = (req.lba % CHS_SECT) + 32'd1;
      track_base = req.lba - (sector_num - 32'd1);
      // Big disks overflow the cylinder registers; only the low 16 bits survive.
      cylinder = track_base / (ChsHeads * CHS_SECT);
      tf.addr_byte0 = sector_num[7:0];
      tf.addr_byte1 = cylinder[7:0];
      tf.addr_byte2 = cylinder[15:8];
      head = 4'((track_base % (ChsHeads * CHS_SECT)) / CHS_SECT);
      base = DEV_BASE_CHS;
    end
    tf.device_head = base | {3'b000, req.is_slave, head};
    // The flush command follows the addressing mode even for reads.
    if (tf.address_mode == MODE_LBA48) begin
      tf.command_code = req.direction ? CMD_WRITE_EXT : CMD_READ_EXT;
      tf.flush_code = CMD_FLUSH_EXT;
    end else begin
      tf.command_code = req.direction ? CMD_WRITE : CMD_READ;
      tf.flush_code = CMD_FLUSH;
    end
    return tf;
  endfunction

  // One line per mismatch; after a burst of failures the printing stops but the
  // count keeps going, so a badly broken block does not flood the log.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("%0d ns: mismatch on %s (result %0d): got 0x%0h, expected 0x%0h",
               $time, what, checked_count, got, want);
    end
  endtask

  function automatic sector_request_t make_request(input logic dir, input logic [31:0] lba,
                                                   input logic [7:0] cnt, input logic slave,
                                                   input logic capable);
    sector_request_t req;
    req.direction = dir;
    req.lba = lba;
    req.sector_count = cnt;
    req.is_slave = slave;
    req.lba_capable = capable;
    return req;
  endfunction

  // Random request shaped to spend most of its time below the 48-bit boundary,
  // where both the CHS and the 28-bit paths live, while still hitting the top
  // nibble of the address and the edges around 2^28.
  function automatic sector_request_t random_request();
    sector_request_t req;
    logic [31:0]     lba;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: begin
        lba = $urandom_range(0, 4095);
      end
      2, 3, 4, 5: begin
        lba = {4'h0, 28'($urandom)};
      end
      6: begin
        lba = Lba48Floor + 32'($urandom_range(0, 63)) - 32'd32;
      end
      default: begin
        lba = $urandom;
      end
    endcase
    req = make_request(1'($urandom), lba, 8'($urandom), 1'($urandom), 1'($urandom));
    return req;
  endfunction

  // Watchdog: a hung pipeline or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               taskfile_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: at each rising edge it records an accepted transaction, predicts
  // its task-file image, and checks any strobed result against the oldest
  // prediction. Acceptance is handled first so the queue order stays correct
  // even in the impossible case of a purely combinational block.
  always @(posedge clk) begin
    took_request = rst_n && start && !busy;
    if (took_request) begin
      taskfile_t predicted;
      predicted = build_taskfile(make_request(in_direction, in_lba, in_sector_count,
                                              in_is_slave, in_lba_capable));
      taskfile_expect_q.push_back(predicted);
      mode_seen[predicted.address_mode]++;
      accepted_count++;
    end
    if (rst_n && out_valid) begin
      if (taskfile_expect_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_command_code), 32'd0);
      end else begin
        taskfile_t want;
        want = taskfile_expect_q.pop_front();
        if (out_address_mode !== want.address_mode)
          report_mismatch("address_mode", 32'(out_address_mode), 32'(want.address_mode));
        if (out_device_head !== want.device_head)
          report_mismatch("device_head", 32'(out_device_head), 32'(want.device_head));
        if (out_count_byte !== want.count_byte)
          report_mismatch("count_byte", 32'(out_count_byte), 32'(want.count_byte));
        if (out_addr_byte0 !== want.addr_byte0)
          report_mismatch("addr_byte0", 32'(out_addr_byte0), 32'(want.addr_byte0));
        if (out_addr_byte1 !== want.addr_byte1)
          report_mismatch("addr_byte1", 32'(out_addr_byte1), 32'(want.addr_byte1));
        if (out_addr_byte2 !== want.addr_byte2)
          report_mismatch("addr_byte2", 32'(out_addr_byte2), 32'(want.addr_byte2));
        if (out_addr_byte3 !== want.addr_byte3)
          report_mismatch("addr_byte3", 32'(out_addr_byte3), 32'(want.addr_byte3));
        if (out_addr_byte4 !== want.addr_byte4)
          report_mismatch("addr_byte4", 32'(out_addr_byte4), 32'(want.addr_byte4));
        if (out_addr_byte5 !== want.addr_byte5)
          report_mismatch("addr_byte5", 32'(out_addr_byte5), 32'(want.addr_byte5));
        if (out_command_code !== want.command_code)
          report_mismatch("command_code", 32'(out_command_code), 32'(want.command_code));
        if (out_flush_code !== want.flush_code)
          report_mismatch("flush_code", 32'(out_flush_code), 32'(want.flush_code));
        checked_count++;
      end
    end
  end

  // Driver: works on the falling edge so the block sees stable inputs at the
  // next rising edge. A request stays on the pins until a rising edge accepts
  // it. Between transactions it may insert an idle burst, during which the
  // payload pins carry noise with start low. Near the end of the stimulus the
  // bursts stop so back-to-back traffic gets exercised too.
  always @(negedge clk) begin
    if (start && !took_request) begin
      // Still waiting for acceptance; hold everything.
    end else if (idle_left != 0) begin
      idle_left = idle_left - 1;
      start <= 1'b0;
      in_lba <= $urandom;
      in_sector_count <= 8'($urandom);
    end else if (feeding && request_q.size() != 0) begin
      if (request_q.size() > CalmTail && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 10);
        start <= 1'b0;
        in_direction <= 1'($urandom);
        in_is_slave <= 1'($urandom);
        in_lba_capable <= 1'($urandom);
      end else begin
        next_request = request_q.pop_front();
        start <= 1'b1;
        in_direction <= next_request.direction;
        in_lba <= next_request.lba;
        in_sector_count <= next_request.sector_count;
        in_is_slave <= next_request.is_slave;
        in_lba_capable <= next_request.lba_capable;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Stimulus and end-of-run control.
  initial begin
    // Directed requests first: the address extremes of each mode, the CHS
    // track and cylinder boundaries, both directions, both drive selects, and
    // the extremes of the sector count.
    request_q.push_back(make_request(1'b0, 32'd0, 8'd0, 1'b0, 1'b0));
    request_q.push_back(make_request(1'b1, 32'd0, 8'd255, 1'b1, 1'b1));
    request_q.push_back(make_request(1'b0, 32'd62, 8'd1, 1'b0, 1'b0));
    request_q.push_back(make_request(1'b1, 32'd63, 8'd2, 1'b1, 1'b0));
    request_q.push_back(make_request(1'b0, 32'd1007, 8'd8, 1'b0, 1'b0));
    request_q.push_back(make_request(1'b1, 32'd1008, 8'd16, 1'b1, 1'b0));
    // CHS cylinders around and beyond 16 bits: any high part must be dropped.
    request_q.push_back(make_request(1'b0, 32'h0FFF_FFFF, 8'd0, 1'b0, 1'b0));
    request_q.push_back(make_request(1'b1, 32'd66_060_288, 8'd255, 1'b1, 1'b0));
    request_q.push_back(make_request(1'b0, 32'd66_060_287, 8'd128, 1'b0, 1'b0));
    // Largest 28-bit address, with the head nibble fully set.
    request_q.push_back(make_request(1'b0, 32'h0FFF_FFFF, 8'd255, 1'b0, 1'b1));
    request_q.push_back(make_request(1'b1, 32'h0ABC_DEF1, 8'd77, 1'b1, 1'b1));
    request_q.push_back(make_request(1'b0, 32'h0100_0000, 8'd0, 1'b1, 1'b1));
    // At and above the 48-bit boundary, for both capable and non-capable drives;
    // the head nibble must read zero and the flush must be the extended one,
    // also for reads.
    request_q.push_back(make_request(1'b0, 32'h1000_0000, 8'd1, 1'b0, 1'b0));
    request_q.push_back(make_request(1'b1, 32'h1000_0000, 8'd0, 1'b1, 1'b1));
    request_q.push_back(make_request(1'b0, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b0));
    request_q.push_back(make_request(1'b1, 32'hFFFF_FFFF, 8'd170, 1'b0, 1'b1));
    request_q.push_back(make_request(1'b0, 32'hA5A5_5A5A, 8'd85, 1'b0, 1'b1));
    request_q.push_back(make_request(1'b1, 32'h5A5A_A5A5, 8'd170, 1'b1, 1'b0));
    for (int i = 0; i < RandomCount; i++) begin
      request_q.push_back(random_request());
    end
    total_requests = request_q.size();

    // Synchronous reset, held low from the start, then released on a falling edge.
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    feeding = 1'b1;

    // Wait until every request has been accepted and every result checked,
    // then let the pipeline drain so that any stray strobe still shows.
    while (accepted_count != total_requests) @(negedge clk);
    while (taskfile_expect_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Checked %0d task-file results from %0d requests (%0d directed).",
             checked_count, total_requests, total_requests - RandomCount);
    $display("Mode mix: %0d CHS, %0d LBA28, %0d LBA48; %0d mismatches.",
             mode_seen[MODE_CHS], mode_seen[MODE_LBA28], mode_seen[MODE_LBA48],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/atatf_pkg.sv
rtl/ata_taskfile_address_builder.sv
tb/tb_ata_taskfile_address_builder.sv
